FILE: src/periodic_pin_sampler_assert.svh
// assertion macros for the periodic pin sampler
`ifndef PERIODIC_PIN_SAMPLER_ASSERT_SVH
`define PERIODIC_PIN_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// checked outside reset
`define PPS_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// checked on every edge, reset included
`define PPS_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define PPS_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define PPS_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

FILE: src/pps_pkg.sv
// types, codes and constants of the periodic pin sampler
package pps_pkg;

  localparam int DIGITAL_PINS_DEF    = 14;
  localparam int ANALOG_CHANNELS_DEF = 8;
  localparam int HISTORY_DEPTH_DEF   = 16;

  localparam int MODE_W   = 3;
  localparam int PIN_W    = 4;
  localparam int LEVEL_W  = 14;
  localparam int PERIOD_W = 16;
  localparam int LAT_W    = 10;
  localparam int COUNT_W  = 32;
  localparam int AUX_W    = 32;
  localparam int DATA_W   = 32;

  // pin number of each analog channel
  localparam int MAP_N = 8;
  localparam logic [PIN_W-1:0] ANALOG_PIN_LIST [MAP_N] = '{
    4'd0, 4'd1, 4'd4, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_ADC       = 3'd1,
    MODE_DIG_START = 3'd2,
    MODE_DIG_STOP  = 3'd3,
    MODE_DIG_QUERY = 3'd4,
    MODE_ANA_START = 3'd5,
    MODE_ANA_STOP  = 3'd6,
    MODE_ANA_AVG   = 3'd7
  } pps_mode_t;

  localparam logic REPLY_DIGITAL = 1'b0;
  localparam logic REPLY_ANALOG  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CMD,
    ST_AVG_SUM,
    ST_AVG_DIV
  } pps_state_t;

  // one schedule entry; aux is the history of a digital pin, or for an
  // analog channel {wrapped, write index, latest reading}, latest reading from bit 0 up
  typedef struct packed {
    logic                active;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  base;
    logic [AUX_W-1:0]    aux;
  } pps_unit_t;

  // last match wins, unmapped pins give channel 0
  function automatic logic [2:0] channel_of(input logic [PIN_W-1:0] pin,
                                            input int channels);
    logic [2:0] ch;
    ch = '0;
    for (int c = 0; c < MAP_N; c++) begin
      if (c < channels && ANALOG_PIN_LIST[c] == pin) begin
        ch = 3'(c);
      end
    end
    return ch;
  endfunction

endpackage

FILE: src/pps_in_if.sv
// command channel of the periodic pin sampler
interface pps_in_if;
  import pps_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PIN_W-1:0]    pin;
  logic [LEVEL_W-1:0]  pin_levels;
  logic [PERIOD_W-1:0] interval;
  logic [LAT_W-1:0]    reading;

  modport source (output valid, mode, pin, pin_levels, interval, reading, input ready);
  modport sink (input valid, mode, pin, pin_levels, interval, reading, output ready);
endinterface

FILE: src/pps_out_if.sv
// reply channel of the periodic pin sampler
interface pps_out_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic              reply_kind;
  logic [PIN_W-1:0]  reply_pin;
  logic [DATA_W-1:0] reply_data;

  modport source (output valid, reply_kind, reply_pin, reply_data, input ready);
  modport sink (input valid, reply_kind, reply_pin, reply_data, output ready);
endinterface

FILE: src/pps_unit_ram.sv
// schedule table memory, one entry per pin or channel, zero until written
module pps_unit_ram #(
  parameter int DEPTH = 22,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  pps_pkg::pps_unit_t  wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output pps_pkg::pps_unit_t  rdata
);
  import pps_pkg::*;

  pps_unit_t        mem [DEPTH];
  logic [DEPTH-1:0] written;
  pps_unit_t        rd_q;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_written <= written[raddr];
      end
    end
  end

  assign rdata = rd_written ? rd_q : '0;
endmodule

FILE: src/pps_ring_ram.sv
// sample ring memory, all channels in one array
module pps_ring_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pps_pkg::LAT_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [pps_pkg::LAT_W-1:0] rdata
);
  import pps_pkg::*;

  logic [LAT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/pps_avg_div.sv
// ring average divide: division by the ring depth through a reciprocal multiply
module pps_avg_div #(
  parameter int DIVISOR = 16,
  parameter int DIV_W   = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  output logic                      busy,
  output logic [pps_pkg::LAT_W-1:0] quotient
);
  import pps_pkg::*;

  // floor(n * RECIP / 2^SHIFT) equals floor(n / DIVISOR) for every DIV_W-bit n
  localparam int     SHIFT   = DIV_W + $clog2(DIVISOR);
  localparam int     RECIP_W = DIV_W + 2;
  localparam int     PROD_W  = DIV_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) /
                               longint'(DIVISOR);

  logic [DIV_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));

  // sum is latched first, multiply runs in the busy cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (busy) begin
      quotient <= LAT_W'(prod >> SHIFT);
    end
  end
endmodule

FILE: src/periodic_pin_sampler.sv
// periodic pin sampler: schedule walk, commands and queries over two memories
//
//   channel  dir  payload                                   transfer when
//   cmd      in   mode, pin, pin_levels, interval, reading  valid && ready
//   reply    out  reply_kind, reply_pin, reply_data         valid && ready
//
// a tick walks every table entry in order, one table read per entry
// start, stop and reading do a table read, then a write back; a digital query reads the table and loads the reply
// analog average: one ring read per entry, then a registered reciprocal divide
// cmd ready is high only while idle; a reply waits in its own register, and a
// query that finds that register still full holds until it drains
// synchronous reset clears the table valid bits and the tick count at once
`include "periodic_pin_sampler_assert.svh"

module periodic_pin_sampler #(
  parameter int DIGITAL_PINS    = pps_pkg::DIGITAL_PINS_DEF,
  parameter int ANALOG_CHANNELS = pps_pkg::ANALOG_CHANNELS_DEF,
  parameter int HISTORY_DEPTH   = pps_pkg::HISTORY_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  pps_in_if.sink   cmd,
  pps_out_if.source reply
);
  import pps_pkg::*;

  localparam int UNIT_N  = DIGITAL_PINS + ANALOG_CHANNELS;
  localparam int UNIT_AW = $clog2(UNIT_N);
  localparam int LV_W    = 2 ** UNIT_AW;
  localparam int RING_N  = ANALOG_CHANNELS * HISTORY_DEPTH;
  localparam int RING_AW = $clog2(RING_N);
  localparam int IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int CH_W    = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
  localparam int SUM_W   = LAT_W + IDX_W;

  pps_state_t state, state_next;

  // accepted item
  pps_mode_t           it_mode;
  logic [PIN_W-1:0]    it_pin;
  logic [LEVEL_W-1:0]  it_levels;
  logic [PERIOD_W-1:0] it_interval;
  logic [LAT_W-1:0]    it_reading;

  logic [COUNT_W-1:0]  tick_count;
  logic [UNIT_AW-1:0]  unit_addr;

  // table ports
  logic               unit_we, unit_re;
  logic [UNIT_AW-1:0] unit_waddr, unit_raddr;
  pps_unit_t          unit_wdata, ent;

  // ring ports
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [LAT_W-1:0]   ring_wdata, ring_rdata;

  // average
  logic [IDX_W-1:0] avg_idx, avg_widx, avg_idx_inc;
  logic             avg_wrapped;
  logic [SUM_W-1:0] avg_sum, sum_next;
  logic [LAT_W-1:0] avg_val;
  logic             div_start, div_busy;
  logic [LAT_W-1:0] div_q;

  // reply register
  logic              rsp_valid, rsp_kind, rsp_load, rsp_kind_next;
  logic [PIN_W-1:0]  rsp_pin;
  logic [DATA_W-1:0] rsp_data, rsp_data_next;
  logic              out_free;

  logic               accept;
  pps_mode_t          in_mode;
  logic [CH_W-1:0]    in_ch;
  logic [UNIT_AW-1:0] acc_addr;
  logic               dig_ok;

  // decode of the entry in the read register
  logic               ent_is_analog, fire, walk_last, lv_bit;
  logic [COUNT_W-1:0] elapsed;
  logic [CH_W-1:0]    ent_ch;
  logic [IDX_W-1:0]   ent_widx;
  logic               ent_wrapped, widx_last;
  logic [LAT_W-1:0]   ent_latest;
  logic [RING_AW-1:0] ring_base;
  logic [LV_W-1:0]    lv_ext;
  pps_unit_t          walk_entry;

  assign accept  = cmd.valid && cmd.ready;
  assign in_mode = pps_mode_t'(cmd.mode);
  assign in_ch   = CH_W'(channel_of(cmd.pin, ANALOG_CHANNELS));
  assign dig_ok  = (5'(it_pin) < 5'(DIGITAL_PINS));
  assign out_free = !rsp_valid || reply.ready;

  always_comb begin
    case (in_mode)
      MODE_TICK: acc_addr = '0;
      MODE_DIG_START, MODE_DIG_STOP, MODE_DIG_QUERY: acc_addr = UNIT_AW'(cmd.pin);
      default: acc_addr = UNIT_AW'(DIGITAL_PINS) + UNIT_AW'(in_ch);
    endcase
  end

  assign ent_is_analog = unit_addr >= UNIT_AW'(DIGITAL_PINS);
  assign elapsed       = tick_count - ent.base;
  assign fire          = ent.active && (elapsed >= COUNT_W'(ent.period));
  assign walk_last     = unit_addr == UNIT_AW'(UNIT_N - 1);
  assign ent_ch        = CH_W'(unit_addr - UNIT_AW'(DIGITAL_PINS));
  assign ent_latest    = ent.aux[LAT_W-1:0];
  assign ent_widx      = ent.aux[LAT_W +: IDX_W];
  assign ent_wrapped   = ent.aux[LAT_W + IDX_W];
  assign widx_last     = ent_widx == IDX_W'(HISTORY_DEPTH - 1);
  assign ring_base     = RING_AW'(int'(ent_ch) * HISTORY_DEPTH);
  assign lv_ext        = LV_W'(it_levels);
  assign lv_bit        = lv_ext[unit_addr];

  always_comb begin
    walk_entry      = ent;
    walk_entry.base = ent.base + COUNT_W'(ent.period);
    if (ent_is_analog) begin
      walk_entry.aux[LAT_W +: IDX_W]  = widx_last ? '0 : ent_widx + IDX_W'(1);
      walk_entry.aux[LAT_W + IDX_W]   = ent_wrapped || widx_last;
    end else begin
      walk_entry.aux = {ent.aux[AUX_W-2:0], lv_bit};
    end
  end

  // entries never written since reset count as zero
  assign avg_val     = (avg_wrapped || avg_idx < avg_widx) ? ring_rdata : '0;
  assign sum_next    = avg_sum + SUM_W'(avg_val);
  assign avg_idx_inc = avg_idx + IDX_W'(1);

  always_comb begin
    state_next    = state;
    unit_re       = 1'b0;
    unit_raddr    = '0;
    unit_we       = 1'b0;
    unit_waddr    = unit_addr;
    unit_wdata    = ent;
    ring_re       = 1'b0;
    ring_raddr    = ring_base;
    ring_we       = 1'b0;
    ring_waddr    = ring_base + RING_AW'(ent_widx);
    ring_wdata    = ent_latest;
    div_start     = 1'b0;
    rsp_load      = 1'b0;
    rsp_kind_next = REPLY_DIGITAL;
    rsp_data_next = ent.aux;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          unit_re    = 1'b1;
          unit_raddr = acc_addr;
          state_next = (in_mode == MODE_TICK) ? ST_WALK : ST_CMD;
        end
      end
      ST_WALK: begin
        if (fire) begin
          unit_we    = 1'b1;
          unit_wdata = walk_entry;
          ring_we    = ent_is_analog;
        end
        if (walk_last) begin
          state_next = ST_IDLE;
        end else begin
          unit_re    = 1'b1;
          unit_raddr = unit_addr + UNIT_AW'(1);
        end
      end
      ST_CMD: begin
        state_next = ST_IDLE;
        case (it_mode)
          MODE_ADC: begin
            unit_we                    = 1'b1;
            unit_wdata.aux[LAT_W-1:0]  = it_reading;
          end
          MODE_DIG_START, MODE_ANA_START: begin
            unit_we           = dig_ok || it_mode == MODE_ANA_START;
            unit_wdata.active = 1'b1;
            unit_wdata.base   = tick_count;
            unit_wdata.period = it_interval;
          end
          MODE_DIG_STOP, MODE_ANA_STOP: begin
            unit_we           = dig_ok || it_mode == MODE_ANA_STOP;
            unit_wdata.active = 1'b0;
            unit_wdata.base   = '0;
            unit_wdata.period = '0;
          end
          MODE_DIG_QUERY: begin
            if (dig_ok) begin
              if (out_free) begin
                rsp_load = 1'b1;
              end else begin
                state_next = ST_CMD;
              end
            end
          end
          MODE_ANA_AVG: begin
            ring_re    = 1'b1;
            state_next = ST_AVG_SUM;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_AVG_SUM: begin
        if (avg_idx == IDX_W'(HISTORY_DEPTH - 1)) begin
          div_start  = 1'b1;
          state_next = ST_AVG_DIV;
        end else begin
          ring_re    = 1'b1;
          ring_raddr = ring_base + RING_AW'(avg_idx_inc);
        end
      end
      ST_AVG_DIV: begin
        rsp_kind_next = REPLY_ANALOG;
        rsp_data_next = DATA_W'(div_q);
        if (!div_busy && out_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_mode == MODE_TICK) begin
        tick_count <= tick_count + COUNT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (reply.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_mode     <= in_mode;
      it_pin      <= cmd.pin;
      it_levels   <= cmd.pin_levels;
      it_interval <= cmd.interval;
      it_reading  <= cmd.reading;
    end
    if (unit_re) begin
      unit_addr <= unit_raddr;
    end
    if (state == ST_CMD && it_mode == MODE_ANA_AVG) begin
      avg_idx     <= '0;
      avg_sum     <= '0;
      avg_widx    <= ent_widx;
      avg_wrapped <= ent_wrapped;
    end else if (state == ST_AVG_SUM) begin
      avg_idx <= avg_idx_inc;
      avg_sum <= sum_next;
    end
    if (rsp_load) begin
      rsp_kind <= rsp_kind_next;
      rsp_pin  <= it_pin;
      rsp_data <= rsp_data_next;
    end
  end

  assign cmd.ready        = state == ST_IDLE;
  assign reply.valid      = rsp_valid;
  assign reply.reply_kind = rsp_kind;
  assign reply.reply_pin  = rsp_pin;
  assign reply.reply_data = rsp_data;

  pps_unit_ram #(
    .DEPTH (UNIT_N),
    .AW    (UNIT_AW)
  ) u_unit_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (unit_we),
    .waddr (unit_waddr),
    .wdata (unit_wdata),
    .re    (unit_re),
    .raddr (unit_raddr),
    .rdata (ent)
  );

  pps_ring_ram #(
    .DEPTH (RING_N),
    .AW    (RING_AW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  pps_avg_div #(
    .DIVISOR (HISTORY_DEPTH),
    .DIV_W   (SUM_W)
  ) u_avg_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .busy     (div_busy),
    .quotient (div_q)
  );

  `PPS_ASSERT(a_no_same_entry_rw, clk, rst, (unit_we && unit_re) |-> (unit_waddr != unit_raddr), "table read and write hit the same entry")
  `PPS_ASSERT(a_ring_write_in_walk, clk, rst, ring_we |-> (state == ST_WALK && ent_is_analog), "ring written outside the analog walk")
  `PPS_ASSERT(a_div_start_idle, clk, rst, div_start |-> !div_busy, "divider restarted while busy")
  `PPS_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == ST_IDLE && !rsp_valid), "control not cleared by reset")
endmodule
